FILE: hdl/cfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked frame parser package
// Shared word types, constants, status codes and the CRC-16/XMODEM byte step.
// ----------------------------------------------------------------------------
package cfp_pkg;

    // Frame layout and limits.
    localparam int          MIN_FRAME_BYTES = 9;
    localparam logic [8:0]  POS_LIMIT       = 9'd511;
    localparam logic [15:0] CRC_POLY        = 16'h1021;
    localparam logic [15:0] CRC_INIT        = 16'h0000;
    localparam logic [15:0] MAX_LEN_RESET   = 16'd255;

    // Default depth of the output queue (at least two).
    localparam int CFP_FIFO_DEPTH = 4;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_HDR_FIRST  = 2'd0;
    localparam logic [1:0] REG_HDR_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_LEN    = 2'd2;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_LEN_ERR    = 2'd1;
    localparam logic [1:0] ST_HDR_ERR    = 2'd2;
    localparam logic [1:0] ST_CRC_ERR    = 2'd3;

    // Input word.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_buffer;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  version_field;
        logic [7:0]  control_field;
        logic [7:0]  command_field;
        logic [15:0] length_field;
        logic [1:0]  frame_status;
        logic        last_result;
    } t_out_word;

    // One byte of CRC-16/XMODEM, MSB first, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/cfp_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result word queue
// Small register queue that takes up to two words per cycle and hands out one.
// ----------------------------------------------------------------------------
module cfp_out_fifo
    import cfp_pkg::*;
#(
    parameter int DEPTH = CFP_FIFO_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_out_word i_push_word0,
    input  t_out_word i_push_word1,
    output logic      o_room2,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(DEPTH);

    t_out_word        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] w_wr_ptr1;
    logic             w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Handshake status.
    assign o_valid  = (r_count != '0);
    assign o_room2  = (r_count <= CNT_W'(DEPTH - 2));
    assign o_word   = r_mem[r_rd_ptr];
    assign w_pop    = o_valid & i_ready;
    assign w_wr_ptr1 = ptr_inc(r_wr_ptr);

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push_cnt == 2'd1) begin
            n_wr_ptr = w_wr_ptr1;
        end else if (i_push_cnt == 2'd2) begin
            n_wr_ptr = ptr_inc(w_wr_ptr1);
        end
        n_rd_ptr = w_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push_cnt) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage: the first word goes to the write pointer, a second one after it.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_push_cnt != 2'd0 && r_wr_ptr == PTR_W'(i)) begin
                r_mem[i] <= i_push_word0;
            end else if (i_push_cnt == 2'd2 && w_wr_ptr1 == PTR_W'(i)) begin
                r_mem[i] <= i_push_word1;
            end
        end
    end

    // The queue never holds more words than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("output queue count above depth");

    // A push never lands on a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_count) + int'(i_push_cnt)) <= DEPTH)
        else $error("output queue overflow");

    // A pop without a push lowers the count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && i_push_cnt == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("output queue count not lowered on pop");

endmodule

FILE: hdl/crc_checked_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked frame parser
// Checks the header of a received buffer, captures its fields, forwards the
// payload bytes and closes each buffer with a status word after CRC-16/XMODEM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Word
//  input     in         i_in_valid / o_in_ready       t_in_word  (one byte)
//  output    out        o_out_valid / i_out_ready     t_out_word (payload or status)
//  config    in         psel, penable, pwrite, pready 32-bit APB, regs at 0x0/0x4/0x8
//
//  Each byte is parsed in the cycle it is accepted; its result words, none,
//  one or two, enter the output queue at that edge. A byte is taken every
//  cycle while the queue has room for two words; the queue drains one word
//  per cycle while i_out_ready is high, so stalls only start when it backs up.
//  Synchronous active-low reset clears the frame state, the queue and the
//  registers (header bytes 0, maximum length 255).
// ----------------------------------------------------------------------------
module crc_checked_frame_parser
    import cfp_pkg::*;
#(
    parameter int FIFO_DEPTH = CFP_FIFO_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration registers.
    logic [7:0]  r_hdr_first;
    logic [7:0]  r_hdr_second;
    logic [15:0] r_max_len;

    // Frame state.
    logic [8:0]  r_byte_pos;
    logic        r_header_matched;
    logic [7:0]  r_version;
    logic [7:0]  r_control;
    logic [7:0]  r_command;
    logic [15:0] r_length;
    logic [15:0] r_rx_crc;
    logic [15:0] r_crc;

    // Next frame state for the byte on the input.
    logic [8:0]  n_byte_pos;
    logic        n_header_matched;
    logic [7:0]  n_version;
    logic [7:0]  n_control;
    logic [7:0]  n_command;
    logic [15:0] n_length;
    logic [15:0] n_rx_crc;
    logic [15:0] n_crc;

    logic        w_accept;
    logic        w_active;
    logic        w_len_ok;
    logic        w_in_payload;
    logic        w_emit;
    logic        w_do_crc;
    logic [15:0] w_pos16;
    logic [1:0]  w_status;
    logic [1:0]  w_push_cnt;
    logic        w_room2;
    logic [7:0]  w_b;
    t_out_word   w_payload_word;
    t_out_word   w_status_word;
    t_out_word   w_push_word0;

    // Configuration port: always ready, writes decoded on the word address.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= '0;
            r_hdr_second <= '0;
            r_max_len    <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_HDR_FIRST:  r_hdr_first  <= pwdata[7:0];
                REG_HDR_SECOND: r_hdr_second <= pwdata[7:0];
                REG_MAX_LEN:    r_max_len    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_HDR_FIRST:  prdata = {24'd0, r_hdr_first};
            REG_HDR_SECOND: prdata = {24'd0, r_hdr_second};
            REG_MAX_LEN:    prdata = {16'd0, r_max_len};
            default:        prdata = '0;
        endcase
    end

    assign w_accept   = i_in_valid & o_in_ready;
    assign o_in_ready = w_room2;
    assign w_b        = i_in_word.rx_byte;
    assign w_active   = (r_byte_pos != POS_LIMIT);
    assign w_pos16    = {7'd0, r_byte_pos};

    // Field capture by byte position; a saturated count leaves all fields alone.
    always_comb begin
        n_header_matched = r_header_matched;
        n_version        = r_version;
        n_control        = r_control;
        n_command        = r_command;
        n_length         = r_length;
        n_rx_crc         = r_rx_crc;
        n_byte_pos       = r_byte_pos;
        if (w_active) begin
            n_byte_pos = r_byte_pos + 1'b1;
            unique case (r_byte_pos)
                9'd0: n_header_matched = r_header_matched & (w_b == r_hdr_first);
                9'd1: n_header_matched = r_header_matched & (w_b == r_hdr_second);
                9'd2: n_version = w_b;
                9'd3: n_control = w_b;
                9'd4: n_command = w_b;
                9'd5: n_length  = {w_b, 8'h00};
                9'd6: n_length  = {r_length[15:8], w_b};
                9'd7: n_rx_crc  = {w_b, 8'h00};
                9'd8: n_rx_crc  = {r_rx_crc[15:8], w_b};
                default: ;
            endcase
        end
    end

    // Payload window and CRC coverage: header bytes 0 to 6, then the payload.
    assign w_len_ok     = (n_length >= 16'(MIN_FRAME_BYTES)) && (n_length <= r_max_len);
    assign w_in_payload = w_active && (w_pos16 >= 16'(MIN_FRAME_BYTES)) && (w_pos16 < n_length);
    assign w_do_crc     = (w_active && (r_byte_pos <= 9'd6)) || w_in_payload;
    assign n_crc        = w_do_crc ? crc_byte(r_crc, w_b) : r_crc;
    assign w_emit       = w_in_payload && n_header_matched && w_len_ok;

    // Status checks; the first failing one decides.
    always_comb begin
        priority if (n_byte_pos < 9'(MIN_FRAME_BYTES)) begin
            w_status = ST_LEN_ERR;
        end else if (!n_header_matched) begin
            w_status = ST_HDR_ERR;
        end else if (!w_len_ok) begin
            w_status = ST_LEN_ERR;
        end else if (n_length > {7'd0, n_byte_pos}) begin
            w_status = ST_LEN_ERR;
        end else if (n_crc != n_rx_crc) begin
            w_status = ST_CRC_ERR;
        end else begin
            w_status = ST_OK;
        end
    end

    // Result words.
    always_comb begin
        w_payload_word               = '0;
        w_payload_word.result_kind   = KIND_PAYLOAD;
        w_payload_word.payload_byte  = w_b;
        w_payload_word.payload_index = w_pos16 - 16'(MIN_FRAME_BYTES);

        w_status_word               = '0;
        w_status_word.result_kind   = KIND_STATUS;
        w_status_word.version_field = n_version;
        w_status_word.control_field = n_control;
        w_status_word.command_field = n_command;
        w_status_word.length_field  = n_length;
        w_status_word.frame_status  = w_status;
        w_status_word.last_result   = 1'b1;
    end

    // A payload word goes first when the last byte carries payload too.
    assign w_push_word0 = w_emit ? w_payload_word : w_status_word;
    assign w_push_cnt   = w_accept ? (2'(w_emit) + 2'(i_in_word.end_of_buffer)) : 2'd0;

    // Frame state register: cleared after the status word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_in_word.end_of_buffer)) begin
            r_byte_pos       <= '0;
            r_header_matched <= 1'b1;
            r_version        <= '0;
            r_control        <= '0;
            r_command        <= '0;
            r_length         <= '0;
            r_rx_crc         <= '0;
            r_crc            <= CRC_INIT;
        end else if (w_accept) begin
            r_byte_pos       <= n_byte_pos;
            r_header_matched <= n_header_matched;
            r_version        <= n_version;
            r_control        <= n_control;
            r_command        <= n_command;
            r_length         <= n_length;
            r_rx_crc         <= n_rx_crc;
            r_crc            <= n_crc;
        end
    end

    // Output queue.
    cfp_out_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (w_push_cnt),
        .i_push_word0(w_push_word0),
        .i_push_word1(w_status_word),
        .o_room2     (w_room2),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_word      (o_out_word)
    );

    // The word after a buffer's last byte starts a fresh frame.
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_word.end_of_buffer) |=> (r_byte_pos == '0 && r_header_matched))
        else $error("frame state not cleared after status");

    // Payload words only come from a frame whose header matched.
    a_payload_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit) |-> (r_header_matched && r_byte_pos >= 9'(MIN_FRAME_BYTES)))
        else $error("payload word from unmatched header");

    // A saturated byte count stays saturated until the buffer ends.
    a_pos_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_in_word.end_of_buffer && r_byte_pos == POS_LIMIT)
        |=> (r_byte_pos == POS_LIMIT))
        else $error("byte count left saturation");

endmodule

FILE: tb/crc_checked_frame_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CRC-checked frame parser testbench
// Feeds buffers of bytes to the parser, good frames and flawed ones, under
// several register settings and random idling on both channels. A local
// model of the parser predicts every payload and status word, and a monitor
// compares each word taken from the output channel, field by field.
// ----------------------------------------------------------------------------
module crc_checked_frame_parser_test;
    import cfp_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    typedef enum {FLAW_NONE, FLAW_HDR_FIRST, FLAW_HDR_SECOND, FLAW_CRC} t_frame_flaw;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_word   = '0;
    logic                  out_ready = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    crc_checked_frame_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Words waiting to be sent and words the parser is expected to produce.
    t_in_word  byte_queue[$];
    t_out_word expected_words[$];
    int        queued_bytes = 0;
    int        mismatches   = 0;

    // Idling bounds for the current phase and the long hold-off request.
    int in_gap_max    = 10;
    int out_stall_max = 10;
    int hold_request  = 0;

    // Shadow copy of the configuration registers.
    logic [7:0]  cfg_hdr_first  = 8'h00;
    logic [7:0]  cfg_hdr_second = 8'h00;
    logic [15:0] cfg_max_len    = MAX_LEN_RESET;

    // Frame state of the local parser model.
    logic [8:0]  frame_pos     = '0;
    logic        hdr_ok        = 1'b1;
    logic [7:0]  frame_version = '0;
    logic [7:0]  frame_control = '0;
    logic [7:0]  frame_command = '0;
    logic [15:0] frame_length  = '0;
    logic [15:0] frame_crc_rx  = '0;
    logic [15:0] run_crc       = CRC_INIT;

    // CRC-16/XMODEM over one byte, one data bit at a time.
    function automatic logic [15:0] crc16_xmodem(input logic [15:0] crc,
                                                 input logic [7:0] data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ data[k];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic length_in_range();
        return frame_length >= MIN_FRAME_BYTES && frame_length <= cfg_max_len;
    endfunction

    task automatic clear_frame();
        frame_pos     = '0;
        hdr_ok        = 1'b1;
        frame_version = '0;
        frame_control = '0;
        frame_command = '0;
        frame_length  = '0;
        frame_crc_rx  = '0;
        run_crc       = CRC_INIT;
    endtask

    // Advance the model by one accepted byte and queue the words it causes.
    task automatic parse_byte(input t_in_word w);
        int         p;
        logic [1:0] status;
        t_out_word  res;
        p = frame_pos;
        if (p < POS_LIMIT) begin
            case (p)
                0: hdr_ok = hdr_ok && (w.rx_byte == cfg_hdr_first);
                1: hdr_ok = hdr_ok && (w.rx_byte == cfg_hdr_second);
                2: frame_version = w.rx_byte;
                3: frame_control = w.rx_byte;
                4: frame_command = w.rx_byte;
                5: frame_length = {w.rx_byte, 8'h00};
                6: frame_length[7:0] = w.rx_byte;
                7: frame_crc_rx = {w.rx_byte, 8'h00};
                8: frame_crc_rx[7:0] = w.rx_byte;
                default: ;
            endcase
            if (p <= 6) begin
                run_crc = crc16_xmodem(run_crc, w.rx_byte);
            end
            // Payload bytes up to the length field; trailing bytes are skipped.
            if (p >= MIN_FRAME_BYTES && p < frame_length) begin
                run_crc = crc16_xmodem(run_crc, w.rx_byte);
                if (hdr_ok && length_in_range()) begin
                    res               = '0;
                    res.result_kind   = KIND_PAYLOAD;
                    res.payload_byte  = w.rx_byte;
                    res.payload_index = 16'(p - MIN_FRAME_BYTES);
                    expected_words.push_back(res);
                end
            end
            frame_pos = 9'(p + 1);
        end
        if (w.end_of_buffer) begin
            // The first failing check decides the status.
            if (frame_pos < MIN_FRAME_BYTES) begin
                status = ST_LEN_ERR;
            end else if (!hdr_ok) begin
                status = ST_HDR_ERR;
            end else if (!length_in_range()) begin
                status = ST_LEN_ERR;
            end else if (frame_length > frame_pos) begin
                status = ST_LEN_ERR;
            end else if (run_crc != frame_crc_rx) begin
                status = ST_CRC_ERR;
            end else begin
                status = ST_OK;
            end
            res               = '0;
            res.result_kind   = KIND_STATUS;
            res.version_field = frame_version;
            res.control_field = frame_control;
            res.command_field = frame_command;
            res.length_field  = frame_length;
            res.frame_status  = status;
            res.last_result   = 1'b1;
            expected_words.push_back(res);
            clear_frame();
        end
    endtask

    // Driver: offers the next pending word after a random gap.
    int gap_left = 0;

    always @(posedge i_clk) begin
        logic busy;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            busy = in_valid;
            if (in_valid && o_in_ready) begin
                parse_byte(in_word);
                busy = 1'b0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    in_word  <= byte_queue.pop_front();
                    in_valid <= 1'b1;
                    gap_left = $urandom_range(0, in_gap_max);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: checks each accepted word and stalls the output at random.
    int stall_left  = 0;
    int hold_left   = 0;
    int hold_served = 0;

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t ns: unexpected word, expected none, actual %h",
                             $time, o_out_word);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    report_field("result_kind", want.result_kind, o_out_word.result_kind);
                    report_field("payload_byte", want.payload_byte, o_out_word.payload_byte);
                    report_field("payload_index", want.payload_index,
                                 o_out_word.payload_index);
                    report_field("version_field", want.version_field,
                                 o_out_word.version_field);
                    report_field("control_field", want.control_field,
                                 o_out_word.control_field);
                    report_field("command_field", want.command_field,
                                 o_out_word.command_field);
                    report_field("length_field", want.length_field, o_out_word.length_field);
                    report_field("frame_status", want.frame_status, o_out_word.frame_status);
                    report_field("last_result", want.last_result, o_out_word.last_result);
                end
                stall_left = $urandom_range(0, out_stall_max);
            end
            if (hold_served != hold_request) begin
                hold_served = hold_request;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Waits until every word is sent and every expected word has arrived.
    // The check runs just after the edge, once the driver's updates settled.
    task automatic wait_drained();
        while (byte_queue.size() != 0 || in_valid || expected_words.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HDR_FIRST:  cfg_hdr_first  = value[7:0];
            REG_HDR_SECOND: cfg_hdr_second = value[7:0];
            REG_MAX_LEN:    cfg_max_len    = value[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [7:0] hdr_first, input logic [7:0] hdr_second,
                                input logic [15:0] max_len);
        wait_drained();
        write_reg(REG_HDR_FIRST, {24'h0, hdr_first});
        write_reg(REG_HDR_SECOND, {24'h0, hdr_second});
        write_reg(REG_MAX_LEN, {16'h0, max_len});
    endtask

    task automatic push_byte(input logic [7:0] value, input logic last);
        t_in_word w;
        w.rx_byte       = value;
        w.end_of_buffer = last;
        byte_queue.push_back(w);
        queued_bytes++;
    endtask

    // Builds one buffer: header from the current registers, the given length
    // field, random fields and payload, a matching CRC unless flawed.
    task automatic queue_frame(input int len_field, input int n_bytes, input t_frame_flaw flaw);
        logic [7:0]  frame_bytes[];
        logic [15:0] len_bits;
        logic [15:0] crc;
        logic [7:0]  flip;
        int          span;
        frame_bytes = new[(n_bytes < MIN_FRAME_BYTES) ? MIN_FRAME_BYTES : n_bytes];
        for (int i = 0; i < frame_bytes.size(); i++) begin
            frame_bytes[i] = 8'($urandom_range(0, 255));
        end
        len_bits       = 16'(len_field);
        flip           = 8'($urandom_range(1, 255));
        frame_bytes[0] = cfg_hdr_first ^ ((flaw == FLAW_HDR_FIRST) ? flip : 8'h00);
        frame_bytes[1] = cfg_hdr_second ^ ((flaw == FLAW_HDR_SECOND) ? flip : 8'h00);
        frame_bytes[5] = len_bits[15:8];
        frame_bytes[6] = len_bits[7:0];
        crc = CRC_INIT;
        for (int i = 0; i < 7; i++) begin
            crc = crc16_xmodem(crc, frame_bytes[i]);
        end
        span = len_field;
        if (n_bytes < span) span = n_bytes;
        if (span > POS_LIMIT) span = POS_LIMIT;
        for (int i = MIN_FRAME_BYTES; i < span; i++) begin
            crc = crc16_xmodem(crc, frame_bytes[i]);
        end
        if (flaw == FLAW_CRC) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end
        frame_bytes[7] = crc[15:8];
        frame_bytes[8] = crc[7:0];
        for (int i = 0; i < n_bytes; i++) begin
            push_byte(frame_bytes[i], i == n_bytes - 1);
        end
    endtask

    // Random bytes with random buffer ends; the last one closes the buffer.
    task automatic queue_noise(input int n_bytes);
        for (int i = 0; i < n_bytes; i++) begin
            push_byte(8'($urandom_range(0, 255)),
                      (i == n_bytes - 1) || ($urandom_range(0, 5) == 0));
        end
    endtask

    // Mostly well-formed frames, with some flawed, short or broken ones.
    task automatic queue_random_frame();
        int cap;
        int good_len;
        int r;
        int len;
        cap      = (cfg_max_len < 40) ? cfg_max_len : 40;
        good_len = $urandom_range(MIN_FRAME_BYTES, cap);
        r        = $urandom_range(0, 99);
        if (r < 60) begin
            queue_frame(good_len,
                        good_len + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0),
                        FLAW_NONE);
        end else if (r < 68) begin
            queue_frame(good_len, good_len, FLAW_CRC);
        end else if (r < 74) begin
            queue_frame(good_len, good_len,
                        ($urandom_range(0, 1) == 0) ? FLAW_HDR_FIRST : FLAW_HDR_SECOND);
        end else if (r < 79) begin
            queue_frame(good_len, $urandom_range(1, MIN_FRAME_BYTES - 1), FLAW_NONE);
        end else if (r < 84) begin
            queue_frame($urandom_range(0, MIN_FRAME_BYTES - 1), $urandom_range(9, 15),
                        FLAW_NONE);
        end else if (r < 89) begin
            len = cfg_max_len + $urandom_range(1, 20);
            if (len > 65535) len = $urandom_range(512, 65535);
            queue_frame(len, $urandom_range(9, 20), FLAW_NONE);
        end else if (r < 95) begin
            if (good_len > MIN_FRAME_BYTES) begin
                queue_frame(good_len, $urandom_range(MIN_FRAME_BYTES, good_len - 1), FLAW_NONE);
            end else begin
                queue_frame(good_len, good_len - 1, FLAW_NONE);
            end
        end else begin
            queue_noise($urandom_range(1, 12));
        end
    endtask

    task automatic run_random_phase(input logic [7:0] hdr_first, input logic [7:0] hdr_second,
                                    input logic [15:0] max_len, input int gap_max,
                                    input int stall_max, input logic long_hold,
                                    input int n_bytes);
        int stop_at;
        apply_config(hdr_first, hdr_second, max_len);
        in_gap_max    = gap_max;
        out_stall_max = stall_max;
        if (long_hold) begin
            hold_request++;
        end
        stop_at = queued_bytes + n_bytes;
        while (queued_bytes < stop_at) begin
            queue_random_frame();
        end
    endtask

    // Stimulus and end of run.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset register values.
        queue_frame(9, 9, FLAW_NONE);         // minimum frame, no payload
        queue_frame(10, 10, FLAW_NONE);       // last byte is a payload byte
        queue_frame(9, 4, FLAW_NONE);         // buffer too short
        queue_frame(10, 5, FLAW_HDR_SECOND);  // short buffer wins over bad header
        queue_frame(10, 10, FLAW_HDR_FIRST);  // header error
        queue_frame(10, 10, FLAW_CRC);        // crc mismatch
        queue_frame(8, 9, FLAW_NONE);         // length field below minimum
        queue_frame(256, 12, FLAW_NONE);      // length field above maximum
        queue_frame(12, 10, FLAW_NONE);       // truncated frame
        queue_frame(10, 13, FLAW_NONE);       // trailing bytes ignored

        // Saturated byte count with the widest length limit; the last byte
        // arrives after the count has saturated.
        apply_config(8'hFF, 8'hFF, 16'hFFFF);
        in_gap_max    = 0;
        out_stall_max = 0;
        queue_frame(511, 512, FLAW_NONE);
        queue_frame(9, 9, FLAW_HDR_SECOND);

        // Narrowest length limit.
        apply_config(8'h00, 8'hFF, 16'd9);
        queue_frame(9, 9, FLAW_NONE);
        queue_frame(10, 10, FLAW_NONE);

        // Random phases over several settings and idling patterns.
        run_random_phase(8'hA5, 8'h3C, 16'd255, 10, 10, 1'b0, 30);
        run_random_phase(8'h00, 8'hFF, 16'd9, 0, 0, 1'b0, 20);
        run_random_phase(8'hFF, 8'h00, 16'hFFFF, 0, 10, 1'b1, 30);
        run_random_phase(8'h7E, 8'h81, 16'd40, 3, 0, 1'b0, 20);

        wait_drained();
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/cfp_pkg.sv
hdl/cfp_out_fifo.sv
hdl/crc_checked_frame_parser.sv
tb/crc_checked_frame_parser_test.sv
